FILE: src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// Lidar point ring tagger package
// Shared types, pipeline constants and the beam tables of the tagger.
// ----------------------------------------------------------------------------
package lpr_pkg;

	localparam int COLUMNS_DEF  = 1800;
	localparam int PERIOD_RESET = 5556;
	localparam int SQRT_CELLS   = 32;
	localparam int NORM_CELLS   = 7;
	localparam int CORDIC_STEPS = 20;
	localparam int LANE_LAT     = 1 + NORM_CELLS + CORDIC_STEPS + 1;
	localparam int ANG_W        = 45;
	localparam int MAG_W        = 42;
	localparam int ACC_W        = 27;
	localparam int DEG_W        = 21;
	localparam int NORM_TOP     = 40;
	localparam int HALF_TURN    = 180 * 65536;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
	} in_t;

	typedef struct packed {
		logic [4:0]  ring_number;
		logic [10:0] column_index;
		logic [23:0] fire_time;
	} out_t;

	function automatic int atan_step(input int i);
		case (i)
			0:       atan_step = 2949120;
			1:       atan_step = 1740967;
			2:       atan_step = 919879;
			3:       atan_step = 466945;
			4:       atan_step = 234379;
			5:       atan_step = 117304;
			6:       atan_step = 58666;
			7:       atan_step = 29335;
			8:       atan_step = 14668;
			9:       atan_step = 7334;
			10:      atan_step = 3667;
			11:      atan_step = 1833;
			12:      atan_step = 917;
			13:      atan_step = 458;
			14:      atan_step = 229;
			15:      atan_step = 115;
			16:      atan_step = 57;
			17:      atan_step = 29;
			18:      atan_step = 14;
			19:      atan_step = 7;
			default: atan_step = 0;
		endcase
	endfunction

	function automatic int ring_thr(input int k);
		case (k)
			0:       ring_thr = 1400;
			1:       ring_thr = 1200;
			2:       ring_thr = 1000;
			3:       ring_thr = 800;
			4:       ring_thr = 625;
			5:       ring_thr = 475;
			6:       ring_thr = 333;
			7:       ring_thr = 200;
			8:       ring_thr = 67;
			9:       ring_thr = -67;
			10:      ring_thr = -200;
			11:      ring_thr = -333;
			12:      ring_thr = -467;
			13:      ring_thr = -600;
			14:      ring_thr = -733;
			15:      ring_thr = -900;
			16:      ring_thr = -1150;
			17:      ring_thr = -1450;
			18:      ring_thr = -1750;
			19:      ring_thr = -2050;
			20:      ring_thr = -2350;
			21:      ring_thr = -2650;
			22:      ring_thr = -2950;
			23:      ring_thr = -3250;
			24:      ring_thr = -3550;
			25:      ring_thr = -3850;
			26:      ring_thr = -4150;
			27:      ring_thr = -4450;
			28:      ring_thr = -4750;
			29:      ring_thr = -5050;
			30:      ring_thr = -5350;
			default: ring_thr = -2147483647;
		endcase
	endfunction

	function automatic logic [12:0] ring_time(input logic [4:0] r);
		case (r)
			5'd0:    ring_time = 13'd0;
			5'd1:    ring_time = 13'd157;
			5'd2:    ring_time = 13'd315;
			5'd3:    ring_time = 13'd472;
			5'd4:    ring_time = 13'd630;
			5'd5:    ring_time = 13'd787;
			5'd6:    ring_time = 13'd945;
			5'd7:    ring_time = 13'd1136;
			5'd8:    ring_time = 13'd1326;
			5'd9:    ring_time = 13'd1517;
			5'd10:   ring_time = 13'd1708;
			5'd11:   ring_time = 13'd1899;
			5'd12:   ring_time = 13'd2056;
			5'd13:   ring_time = 13'd2214;
			5'd14:   ring_time = 13'd2371;
			5'd15:   ring_time = 13'd2529;
			5'd16:   ring_time = 13'd2653;
			5'd17:   ring_time = 13'd2777;
			5'd18:   ring_time = 13'd2901;
			5'd19:   ring_time = 13'd3025;
			5'd20:   ring_time = 13'd3149;
			5'd21:   ring_time = 13'd3273;
			5'd22:   ring_time = 13'd3398;
			5'd23:   ring_time = 13'd3522;
			5'd24:   ring_time = 13'd3646;
			5'd25:   ring_time = 13'd3770;
			5'd26:   ring_time = 13'd3894;
			5'd27:   ring_time = 13'd4018;
			5'd28:   ring_time = 13'd4142;
			5'd29:   ring_time = 13'd4267;
			5'd30:   ring_time = 13'd4391;
			default: ring_time = 13'd4515;
		endcase
	endfunction

endpackage

FILE: src/lpr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One result bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module lpr_sqrt_cell #(
	parameter int K = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rem_i,
	input  logic [63:0] res_i,
	output logic [63:0] rem_o,
	output logic [63:0] res_o
);

	localparam logic [63:0] BIT = 64'(1) << (62 - 2 * K);

	logic [64:0] trial;
	logic [63:0] rem_q;
	logic [63:0] res_q;

	assign trial = {1'b0, res_i} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, rem_i} >= trial) begin
				rem_q <= rem_i - trial[63:0];
				res_q <= (res_i >> 1) + BIT;
			end else begin
				rem_q <= rem_i;
				res_q <= res_i >> 1;
			end
		end
	end

	assign rem_o = rem_q;
	assign res_o = res_q;

endmodule

FILE: src/lpr_norm_cell.sv
// ----------------------------------------------------------------------------
// Normalize cell
// Shifts a vector left by a fixed amount while its magnitude stays small.
// ----------------------------------------------------------------------------
module lpr_norm_cell #(
	parameter int S   = 1,
	parameter int LIM = 39
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [lpr_pkg::ANG_W-1:0] x_i,
	input  logic signed [lpr_pkg::ANG_W-1:0] y_i,
	input  logic        [lpr_pkg::MAG_W-1:0] mag_i,
	output logic signed [lpr_pkg::ANG_W-1:0] x_o,
	output logic signed [lpr_pkg::ANG_W-1:0] y_o,
	output logic        [lpr_pkg::MAG_W-1:0] mag_o
);
	import lpr_pkg::*;

	localparam logic [MAG_W-1:0] LIMIT = MAG_W'(64'(1) << LIM);

	logic signed [ANG_W-1:0] x_q;
	logic signed [ANG_W-1:0] y_q;
	logic        [MAG_W-1:0] mag_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (mag_i < LIMIT) begin
				x_q   <= x_i <<< S;
				y_q   <= y_i <<< S;
				mag_q <= mag_i << S;
			end else begin
				x_q   <= x_i;
				y_q   <= y_i;
				mag_q <= mag_i;
			end
		end
	end

	assign x_o   = x_q;
	assign y_o   = y_q;
	assign mag_o = mag_q;

endmodule

FILE: src/lpr_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation step with its angle accumulation, registered.
// ----------------------------------------------------------------------------
module lpr_cordic_cell #(
	parameter int I = 0
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [lpr_pkg::ANG_W-1:0] x_i,
	input  logic signed [lpr_pkg::ANG_W-1:0] y_i,
	input  logic signed [lpr_pkg::ACC_W-1:0] acc_i,
	output logic signed [lpr_pkg::ANG_W-1:0] x_o,
	output logic signed [lpr_pkg::ANG_W-1:0] y_o,
	output logic signed [lpr_pkg::ACC_W-1:0] acc_o
);
	import lpr_pkg::*;

	localparam logic signed [ACC_W-1:0] STEP = ACC_W'(atan_step(I));

	logic signed [ANG_W-1:0] dx;
	logic signed [ANG_W-1:0] dy;
	logic signed [ANG_W-1:0] x_q;
	logic signed [ANG_W-1:0] y_q;
	logic signed [ACC_W-1:0] acc_q;

	assign dx = x_i >>> I;
	assign dy = y_i >>> I;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[ANG_W-1]) begin
				x_q   <= x_i + dy;
				y_q   <= y_i - dx;
				acc_q <= acc_i + STEP;
			end else begin
				x_q   <= x_i - dy;
				y_q   <= y_i + dx;
				acc_q <= acc_i - STEP;
			end
		end
	end

	assign x_o   = x_q;
	assign y_o   = y_q;
	assign acc_o = acc_q;

endmodule

FILE: src/lpr_angle_lane.sv
// ----------------------------------------------------------------------------
// Angle lane
// Quadrant fold, normalize cells, CORDIC cells and rounding of one angle.
// ----------------------------------------------------------------------------
module lpr_angle_lane #(
	parameter int IN_W = 34
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [IN_W-1:0]           vx_i,
	input  logic signed [IN_W-1:0]           vy_i,
	output logic signed [lpr_pkg::DEG_W-1:0] angle_o
);
	import lpr_pkg::*;

	localparam int ZERO_LEN = NORM_CELLS + CORDIC_STEPS;

	function automatic int norm_shift(input int j);
		case (j)
			0:       norm_shift = 32;
			1:       norm_shift = 16;
			2:       norm_shift = 8;
			3:       norm_shift = 4;
			4:       norm_shift = 2;
			default: norm_shift = 1;
		endcase
	endfunction

	logic signed [ANG_W-1:0] px;
	logic signed [ANG_W-1:0] py;
	logic signed [ANG_W-1:0] fx;
	logic signed [ANG_W-1:0] fy;
	logic signed [ANG_W-1:0] ay;
	logic signed [ACC_W-1:0] base_c;

	logic signed [ANG_W-1:0] nx   [NORM_CELLS+1];
	logic signed [ANG_W-1:0] ny   [NORM_CELLS+1];
	logic        [MAG_W-1:0] nmag [NORM_CELLS+1];
	logic signed [ANG_W-1:0] cx   [CORDIC_STEPS+1];
	logic signed [ANG_W-1:0] cy   [CORDIC_STEPS+1];
	logic signed [ACC_W-1:0] cacc [CORDIC_STEPS+1];

	logic signed [ANG_W-1:0] x_s1;
	logic signed [ANG_W-1:0] y_s1;
	logic        [MAG_W-1:0] mag_s1;
	logic signed [ACC_W-1:0] base_s1;
	logic                    zero_s1;
	logic signed [ACC_W-1:0] base_q [NORM_CELLS];
	logic                    zero_q [ZERO_LEN];
	logic signed [DEG_W-1:0] angle_q;
	logic signed [ACC_W-1:0] rnd;

	always_comb begin
		px = ANG_W'(vx_i);
		py = ANG_W'(vy_i);
		base_c = '0;
		fx = px;
		fy = py;
		if (px[ANG_W-1]) begin
			fx = -px;
			fy = -py;
			base_c = py[ANG_W-1] ? ACC_W'(-HALF_TURN) : ACC_W'(HALF_TURN);
		end
		ay = fy[ANG_W-1] ? -fy : fy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= fx;
			y_s1    <= fy;
			mag_s1  <= (fx > ay) ? MAG_W'(fx) : MAG_W'(ay);
			base_s1 <= base_c;
			zero_s1 <= (vx_i == '0) && (vy_i == '0);
			base_q[0] <= base_s1;
			zero_q[0] <= zero_s1;
			for (int j = 1; j < NORM_CELLS; j++) begin
				base_q[j] <= base_q[j-1];
			end
			for (int j = 1; j < ZERO_LEN; j++) begin
				zero_q[j] <= zero_q[j-1];
			end
			angle_q <= zero_q[ZERO_LEN-1] ? '0 : DEG_W'(rnd >>> 6);
		end
	end

	assign nx[0]   = x_s1;
	assign ny[0]   = y_s1;
	assign nmag[0] = mag_s1;

	for (genvar j = 0; j < NORM_CELLS; j++) begin : g_norm
		lpr_norm_cell #(
			.S  (norm_shift(j)),
			.LIM((j == NORM_CELLS - 1) ? NORM_TOP : NORM_TOP - norm_shift(j))
		) u_norm (
			.clk  (clk),
			.en   (en),
			.x_i  (nx[j]),
			.y_i  (ny[j]),
			.mag_i(nmag[j]),
			.x_o  (nx[j+1]),
			.y_o  (ny[j+1]),
			.mag_o(nmag[j+1])
		);
	end

	assign cx[0]   = nx[NORM_CELLS];
	assign cy[0]   = ny[NORM_CELLS];
	assign cacc[0] = base_q[NORM_CELLS-1];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		lpr_cordic_cell #(
			.I(i)
		) u_cordic (
			.clk  (clk),
			.en   (en),
			.x_i  (cx[i]),
			.y_i  (cy[i]),
			.acc_i(cacc[i]),
			.x_o  (cx[i+1]),
			.y_o  (cy[i+1]),
			.acc_o(cacc[i+1])
		);
	end

	assign rnd     = cacc[CORDIC_STEPS] + ACC_W'(32);
	assign angle_o = angle_q;

endmodule

FILE: src/lidar_point_ring_time_tagger.sv
// ----------------------------------------------------------------------------
// Lidar point ring and time tagger
// Tags each point with its laser ring, azimuth column and firing time.
// ----------------------------------------------------------------------------
// Points enter on the in channel (in_valid, in_stall, in_data) and results
// leave on the out channel (out_valid, out_stall, out_data), one result for
// every point, in order. A transfer happens when valid is high and stall low.
// The block takes one point per cycle while the receiver does not stall. The
// pipeline has squaring and summing registers, 32 square root cells, angle
// lanes of 7 normalize and 20 CORDIC cells each, and registers for ring,
// column division and time. The elevation and azimuth lanes run side by side.
// When the receiver stalls, the whole pipeline holds and one more point is
// caught in an input skid register, after which in_stall rises.
// Reset clears all valid flags and the skid flag and sets column_period to its
// reset value. The user must write the column_period register through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module lidar_point_ring_time_tagger #(
	parameter int COLUMNS = lpr_pkg::COLUMNS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [12:0]    cfg_wr_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  lpr_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output lpr_pkg::out_t  out_data
);
	import lpr_pkg::*;

	localparam int  LANE_W = 34;
	localparam int  PIPE   = 2 + SQRT_CELLS + LANE_LAT + 4;
	localparam int  DEN    = 360 * 1024;
	localparam int  OFF    = DEN * COLUMNS;
	localparam longint RECIP = ((64'sd1 <<< 50) + DEN - 1) / DEN;
	localparam logic [31:0] RECIP_W = 32'(RECIP);
	localparam int  COLW   = $clog2(COLUMNS);

	logic [12:0]  period_q;
	in_t          skid_q;
	logic         skid_full_q;
	logic         adv;
	in_t          src;
	logic         src_valid;
	logic         vld_q [PIPE];
	logic         out_valid_q;
	out_t         out_q;

	logic [47:0]  xx_s1;
	logic [47:0]  yy_s1;
	in_t          pt_s1;
	logic [63:0]  v_s2;
	in_t          pt_s2;
	in_t          side_q [SQRT_CELLS];
	logic [63:0]  srem [SQRT_CELLS+1];
	logic [63:0]  sres [SQRT_CELLS+1];

	logic signed [LANE_W-1:0] ev_x;
	logic signed [LANE_W-1:0] ev_y;
	logic signed [LANE_W-1:0] az_x;
	logic signed [LANE_W-1:0] az_y;
	logic signed [DEG_W-1:0]  elev;
	logic signed [DEG_W-1:0]  azim;

	logic signed [31:0] e100;
	logic [4:0]         ring_c;
	logic [4:0]         ring_s3;
	logic signed [31:0] num_s3;
	logic [4:0]         ring_s4;
	logic [30:0]        u_s4;
	logic [4:0]         ring_s5;
	logic [63:0]        p_s5;
	logic signed [COLW+1:0] col_c;
	logic [4:0]         ring_s6;
	logic [COLW-1:0]    col_s6;

	assign adv       = !out_valid_q || !out_stall;
	assign src_valid = skid_full_q || in_valid;
	assign src       = skid_full_q ? skid_q : in_data;
	assign in_stall  = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= 13'(PERIOD_RESET);
			skid_full_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < PIPE; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else begin
			if (cfg_wr_en) begin
				period_q <= cfg_wr_data;
			end
			if (adv) begin
				skid_full_q <= 1'b0;
				vld_q[0]    <= src_valid;
				for (int k = 1; k < PIPE; k++) begin
					vld_q[k] <= vld_q[k-1];
				end
				out_valid_q <= vld_q[PIPE-1];
			end else if (in_valid && !skid_full_q) begin
				skid_full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && in_valid && !skid_full_q) begin
			skid_q <= in_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s1 <= 48'(src.pos_x * src.pos_x);
			yy_s1 <= 48'(src.pos_y * src.pos_y);
			pt_s1 <= src;
			v_s2  <= {16'(49'(xx_s1) + 49'(yy_s1) >> 33), 48'(xx_s1 + yy_s1)} << 16;
			pt_s2 <= pt_s1;
			side_q[0] <= pt_s2;
			for (int k = 1; k < SQRT_CELLS; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	assign srem[0] = v_s2;
	assign sres[0] = '0;

	for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
		lpr_sqrt_cell #(
			.K(k)
		) u_sqrt (
			.clk  (clk),
			.en   (adv),
			.rem_i(srem[k]),
			.res_i(sres[k]),
			.rem_o(srem[k+1]),
			.res_o(sres[k+1])
		);
	end

	assign ev_x = $signed({2'b00, sres[SQRT_CELLS][31:0]});
	assign ev_y = LANE_W'(side_q[SQRT_CELLS-1].pos_z) <<< 8;
	assign az_x = LANE_W'(side_q[SQRT_CELLS-1].pos_x);
	assign az_y = LANE_W'(side_q[SQRT_CELLS-1].pos_y);

	lpr_angle_lane #(
		.IN_W(LANE_W)
	) u_elev (
		.clk    (clk),
		.en     (adv),
		.vx_i   (ev_x),
		.vy_i   (ev_y),
		.angle_o(elev)
	);

	lpr_angle_lane #(
		.IN_W(LANE_W)
	) u_azim (
		.clk    (clk),
		.en     (adv),
		.vx_i   (az_x),
		.vy_i   (az_y),
		.angle_o(azim)
	);

	always_comb begin
		e100   = 32'(elev) * 32'sd100;
		ring_c = 5'd31;
		for (int k = 30; k >= 0; k--) begin
			if (e100 > ring_thr(k) * 1024) begin
				ring_c = 5'(k);
			end
		end
	end

	always_comb begin
		col_c = (COLW+2)'(COLUMNS) - $signed({1'b0, p_s5[50 +: COLW+1]});
		if (col_c[COLW+1]) begin
			col_c = col_c + (COLW+2)'(COLUMNS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ring_s3 <= ring_c;
			num_s3  <= 32'(azim) * 32'(COLUMNS);
			ring_s4 <= ring_s3;
			u_s4    <= 31'(num_s3 + 32'(OFF));
			ring_s5 <= ring_s4;
			p_s5    <= 64'(u_s4) * 64'(RECIP_W);
			ring_s6 <= ring_s5;
			col_s6  <= COLW'(col_c);
			out_q.ring_number  <= ring_s6;
			out_q.column_index <= 11'(col_s6);
			out_q.fire_time    <= 24'(32'(ring_time(ring_s6)) +
				32'(period_q) * 32'(col_s6));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sim/tb_lidar_point_ring_time_tagger.sv
// ----------------------------------------------------------------------------
// Lidar point ring and time tagger testbench
// Drives points through the tagger with random idling on both channels and
// checks ring, column and firing time of every transfer against a predictor or
// against the known results in its point table.
module tb_lidar_point_ring_time_tagger;
	import lpr_pkg::*;

	localparam int COLS = COLUMNS_DEF;
	localparam int WATCH_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [12:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	out_t tag_queue[$];
	logic [12:0] period_now;
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;

	lidar_point_ring_time_tagger dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	localparam longint ATAN_STEP[20] = '{2949120, 1740967, 919879, 466945, 234379,
		117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
	localparam int RING_LIMIT[31] = '{1400, 1200, 1000, 800, 625, 475, 333, 200, 67,
		-67, -200, -333, -467, -600, -733, -900, -1150, -1450, -1750, -2050, -2350,
		-2650, -2950, -3250, -3550, -3850, -4150, -4450, -4750, -5050, -5350};
	localparam int RING_OFFSET[32] = '{0, 157, 315, 472, 630, 787, 945, 1136, 1326,
		1517, 1708, 1899, 2056, 2214, 2371, 2529, 2653, 2777, 2901, 3025, 3149, 3273,
		3398, 3522, 3646, 3770, 3894, 4018, 4142, 4267, 4391, 4515};

	function automatic longint angle_of(input longint vx, input longint vy);
		longint acc, mag, sx, sy;
		acc = 0;
		if (vx == 0 && vy == 0)
			return 0;
		if (vx < 0) begin
			acc = (vy >= 0) ? 180 * 65536 : -180 * 65536;
			vx = -vx;
			vy = -vy;
		end
		mag = ((vx < 0 ? -vx : vx) > (vy < 0 ? -vy : vy)) ? (vx < 0 ? -vx : vx)
			: (vy < 0 ? -vy : vy);
		while (mag < (64'sd1 <<< 40)) begin
			vx = vx * 2;
			vy = vy * 2;
			mag = mag * 2;
		end
		for (int i = 0; i < 20; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				acc += ATAN_STEP[i];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				acc -= ATAN_STEP[i];
			end
		end
		return (acc + 32) >>> 6;
	endfunction

	function automatic longint root_of(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic out_t tag_point(input in_t p, input logic [12:0] period);
		longint x, y, z, elev, azim, num, q, col, den;
		longint unsigned t;
		out_t r;
		int ring;
		x = p.pos_x;
		y = p.pos_y;
		z = p.pos_z;
		den = 360 * 1024;
		elev = angle_of(root_of((x * x + y * y) << 16), z * 256);
		azim = angle_of(x, y);
		ring = 31;
		for (int k = 30; k >= 0; k--)
			if (elev * 100 > longint'(RING_LIMIT[k]) * 1024)
				ring = k;
		num = azim * COLS;
		q = (num >= 0) ? num / den : -((-num + den - 1) / den);
		col = -q;
		if (col < 0)
			col += COLS;
		t = RING_OFFSET[ring] + longint'(period) * col;
		r.ring_number = ring[4:0];
		r.column_index = col[10:0];
		r.fire_time = t[23:0];
		return r;
	endfunction

	typedef struct {
		int x, y, z;
		bit known;
		out_t want;
	} point_row_t;

	point_row_t point_table[$];

	task automatic add_row(input int x, input int y, input int z, input bit known = 1'b0,
		input int ring = 0, input int col = 0, input int ft = 0);
		point_row_t r;
		r.x = x;
		r.y = y;
		r.z = z;
		r.known = known;
		r.want = '{ring_number: 5'(ring), column_index: 11'(col), fire_time: 24'(ft)};
		point_table.insert(point_table.size(), r);
	endtask

	task automatic send_point(input in_t p, input bit known, input out_t want);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		tag_queue.insert(tag_queue.size(), known ? want : tag_point(p, period_now));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic settle_and_write(input logic [12:0] period);
		in_valid <= 1'b0;
		while (tag_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= period;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		period_now = period;
	endtask

	task automatic random_points(input int count);
		in_t p;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 3);
			p.pos_x = 24'($urandom);
			p.pos_y = 24'($urandom);
			p.pos_z = 24'($urandom);
			if (r == 1) begin
				p.pos_x = $signed(p.pos_x) >>> $urandom_range(0, 23);
				p.pos_y = $signed(p.pos_y) >>> $urandom_range(0, 23);
				p.pos_z = $signed(p.pos_z) >>> $urandom_range(0, 23);
			end else if (r == 2) begin
				p.pos_z = $signed(p.pos_z) >>> $urandom_range(1, 8);
			end
			send_point(p, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (tag_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer %p", out_data);
			end else if (out_data !== tag_queue[0]) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p, actual %p", tag_queue[0], out_data);
				void'(tag_queue.pop_front());
			end else begin
				void'(tag_queue.pop_front());
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (calm || $urandom_range(0, 7) != 0) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n || cfg_wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		in_t p;
		period_now = 13'(PERIOD_RESET);
		add_row(0, 0, 0, 1, 9, 0, 1517);
		add_row(4096, 0, 0, 1, 9, 0, 1517);
		add_row(0, 0, 4096, 1, 0, 0, 0);
		add_row(0, 0, -4096, 1, 31, 0, 4515);
		add_row(8388607, 0, 0);
		add_row(-8388608, 0, 0);
		add_row(0, 8388607, 0);
		add_row(0, -8388608, 0);
		add_row(-8388608, -8388608, -8388608);
		add_row(8388607, 8388607, 8388607);
		add_row(-8388608, 8388607, -8388608);
		add_row(8388607, -8388608, 8388607);
		add_row(-1, 0, 0);
		add_row(-1, -1, 0);
		add_row(1, -1, 1);
		add_row(4096, 4096, 500);
		add_row(4096, -4096, -900);
		add_row(-4096, 1, 100);
		add_row(0, 0, 1);
		add_row(0, 0, -1);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (point_table[i]) begin
			p.pos_x = 24'(point_table[i].x);
			p.pos_y = 24'(point_table[i].y);
			p.pos_z = 24'(point_table[i].z);
			send_point(p, point_table[i].known, point_table[i].want);
		end
		random_points(300);
		settle_and_write(13'd0);
		random_points(200);
		settle_and_write(13'd8191);
		random_points(300);
		settle_and_write(13'($urandom));
		random_points(200);
		calm = 1'b1;
		random_points(200);
		in_valid <= 1'b0;
		while (tag_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
